// ===== sv/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg: shared definitions for the console line editor
// Character codes, request and result codes, buffer sizing and the rubout
// echo sequence used by the line editor and its port checker.
// ----------------------------------------------------------------------------
package cle_pkg;

  // Line buffer sizing.
  localparam int LINE_DEPTH = 256;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  // Wide enough to compare an 8-bit index against the buffer depth.
  localparam int WIDE_W     = ((IDX_W > 8) ? IDX_W : 8) + 1;

  // Rubout echo: ESC [ 1 D, space, ESC [ 1 D.
  localparam int RUB_LEN = 9;
  localparam int BEAT_W  = $clog2(RUB_LEN);

  // Character codes.
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CH_CTRLY   = 8'h19;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_G       = 8'h67;
  localparam logic [7:0] CH_P       = 8'h70;

  // Request commands carried on in_tuser.
  typedef enum logic [1:0] {
    CMD_RX    = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Result kinds carried on out_tuser.
  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // Bit positions inside out_tdata.
  localparam int OD_DATA_LSB = 0;
  localparam int OD_DONE     = 8;
  localparam int OD_STATS    = 9;
  localparam int OD_TASKS    = 10;
  localparam int OD_LEN_LSB  = 11;
  localparam int OUT_DATA_W  = 24;

  // Work held in the result sequencer.
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        data;
    logic              rd_ok;
    logic              rub;
    logic [BEAT_W-1:0] beat;
    logic              done;
    logic              stats;
    logic              tasks;
    logic [7:0]        len;
  } seq_t;

  // One result in the output register.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       stats;
    logic       tasks;
    logic [7:0] len;
  } res_t;

  // Byte of the rubout echo for a given beat.
  function automatic logic [7:0] rub_byte(input logic [BEAT_W-1:0] beat);
    logic [7:0] b;
    case (beat)
      BEAT_W'(0): b = CH_ESC;
      BEAT_W'(1): b = CH_BRACKET;
      BEAT_W'(2): b = CH_ONE;
      BEAT_W'(3): b = CH_D;
      BEAT_W'(4): b = CH_SPACE;
      BEAT_W'(5): b = CH_ESC;
      BEAT_W'(6): b = CH_BRACKET;
      BEAT_W'(7): b = CH_ONE;
      BEAT_W'(8): b = CH_D;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/console_line_editor.sv =====
// ----------------------------------------------------------------------------
// console_line_editor: serial console line discipline with echo
// Keeps the received line in a buffer memory, echoes characters and the
// rubout sequence, flags newlines and ctrl-Y magic keys, and serves reads
// and clears of the buffer.
// ----------------------------------------------------------------------------
// Path: a result leaves on out_* through the sequencer stage, then the output
//   register; buffer reads use the same path.
// Throughput: one request per cycle unless the output stalls; a backspace
//   on a nonempty line holds the sequencer for nine echo bytes, one per cycle.
// Reset: rst_n clears the fill count, the ctrl-Y flag and all valid flags;
//   the buffer memory is not cleared and needs no clearing pass.
module console_line_editor
  import cle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,  // [7:0] rx_byte, [15:8] read_index
  input  logic [1:0]            in_tuser,  // [1:0] command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // [7:0] data_byte, [8] line_done,
                                           // [9] magic_stats, [10] magic_tasks,
                                           // [18:11] line_length, [23:19] zero
  output logic [1:0]            out_tuser, // [1:0] kind
  output logic                  out_tlast  // last
);

  // Line buffer memory and its read data register.
  logic [7:0]       mem [LINE_DEPTH];
  logic [7:0]       rd_q;

  // Editor state.
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic             esc_r, esc_nxt;

  // Sequencer and output register.
  seq_t             seq_r, seq_nxt;
  logic             seq_v_r, seq_v_nxt;
  res_t             out_r;
  logic             out_v_r;

  // Request decode.
  logic             in_acc;
  logic [7:0]       c_raw, c_echo;
  logic             is_edit, has_room, produce;
  logic [WIDE_W-1:0] rd_wide;
  logic             rd_ok;
  logic [IDX_W-1:0] raddr;
  logic             mem_we, mem_re;
  logic             seq_move, seq_final;
  res_t             res_nxt;

  assign in_acc   = in_tvalid && in_tready;
  assign c_raw    = in_tdata[7:0];
  assign c_echo   = (c_raw == CH_CR) ? CH_LF : c_raw;
  assign is_edit  = (c_raw == CH_BS) || (c_raw == CH_DEL);
  assign has_room = fill_r < IDX_W'(LINE_DEPTH - 1);
  assign rd_wide  = WIDE_W'(in_tdata[15:8]);
  assign rd_ok    = rd_wide < WIDE_W'(LINE_DEPTH);
  assign raddr    = rd_wide[IDX_W-1:0];

  // Sequencer hand-off to the output register.
  assign seq_move  = seq_v_r && (!out_v_r || out_tready);
  assign seq_final = !seq_r.rub || (seq_r.beat == BEAT_W'(RUB_LEN - 1));
  assign in_tready = !seq_v_r || (seq_move && seq_final);

  // Buffer write of a stored character, read for a read request.
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    case (in_tuser)
      CMD_RX:   mem_we = in_acc && !is_edit && has_room;
      CMD_READ: mem_re = in_acc;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r] <= c_echo;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_q <= mem[raddr];
    end
  end

  // Editor state update and sequencer load.
  always_comb begin
    fill_nxt  = fill_r;
    esc_nxt   = esc_r;
    produce   = 1'b0;
    seq_v_nxt = seq_v_r;
    seq_nxt   = seq_r;

    // Advance or retire the item in the sequencer.
    if (seq_move) begin
      if (seq_final) begin
        seq_v_nxt = 1'b0;
      end else begin
        seq_nxt.beat = seq_r.beat + BEAT_W'(1);
      end
    end

    if (in_acc) begin
      case (in_tuser)
        CMD_RX: begin
          esc_nxt = (c_raw == CH_CTRLY);
          if (is_edit) begin
            if (fill_r != '0) begin
              fill_nxt = fill_r - IDX_W'(1);
              produce  = 1'b1;
            end
          end else begin
            produce = 1'b1;
            if (has_room) begin
              fill_nxt = fill_r + IDX_W'(1);
            end
          end
        end
        CMD_READ:  produce = 1'b1;
        CMD_CLEAR: begin
          fill_nxt = '0;
          produce  = 1'b1;
        end
        default: ;
      endcase
    end

    // A request that causes results enters the sequencer.
    if (produce) begin
      seq_v_nxt     = 1'b1;
      seq_nxt.data  = 8'h00;
      seq_nxt.rd_ok = rd_ok;
      seq_nxt.rub   = 1'b0;
      seq_nxt.beat  = '0;
      seq_nxt.done  = 1'b0;
      seq_nxt.stats = 1'b0;
      seq_nxt.tasks = 1'b0;
      seq_nxt.len   = 8'(fill_nxt);
      case (in_tuser)
        CMD_RX: begin
          seq_nxt.kind = KIND_ECHO;
          if (is_edit) begin
            seq_nxt.rub = 1'b1;
          end else begin
            seq_nxt.data  = c_echo;
            seq_nxt.done  = (c_echo == CH_LF);
            seq_nxt.stats = esc_r && (c_raw == CH_G);
            seq_nxt.tasks = esc_r && (c_raw == CH_P);
          end
        end
        CMD_READ: seq_nxt.kind = KIND_READ;
        default:  seq_nxt.kind = KIND_CLEAR;
      endcase
    end
  end

  // Result formed from the sequencer item.
  always_comb begin
    res_nxt.kind  = seq_r.kind;
    res_nxt.last  = seq_final;
    res_nxt.done  = seq_r.done;
    res_nxt.stats = seq_r.stats;
    res_nxt.tasks = seq_r.tasks;
    res_nxt.len   = seq_r.len;
    if (seq_r.rub) begin
      res_nxt.data = rub_byte(seq_r.beat);
    end else if (seq_r.kind == KIND_READ) begin
      res_nxt.data = seq_r.rd_ok ? rd_q : 8'h00;
    end else begin
      res_nxt.data = seq_r.data;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      esc_r   <= 1'b0;
      seq_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      esc_r   <= esc_nxt;
      seq_v_r <= seq_v_nxt;
      if (seq_move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    if (seq_move) begin
      out_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {5'b00000, out_r.len, out_r.tasks, out_r.stats, out_r.done,
                       out_r.data};

endmodule

// ===== sv/cle_checker.sv =====
// ----------------------------------------------------------------------------
// cle_checker: port-level checks for the console line editor
// Watches the result channel and checks the shape of each result kind
// and the hold of a stalled result.
// ----------------------------------------------------------------------------
module cle_checker
  import cle_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser,
  input logic                  out_tlast
);

  // A stalled result holds still.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // A clear acknowledge is a single result with empty line and zero data.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_CLEAR) |->
      out_tlast && (out_tdata[OD_LEN_LSB+7:OD_LEN_LSB] == 8'h00) &&
      (out_tdata[7:0] == 8'h00) && (out_tdata[OD_TASKS:OD_DONE] == 3'b000))
    else $error("malformed clear acknowledge");

  // A read answer is a single result without flags.
  a_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_READ) |->
      out_tlast && (out_tdata[OD_TASKS:OD_DONE] == 3'b000))
    else $error("malformed read result");

  // Only the rubout echo spans several results, and it carries no flags.
  a_multi: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |->
      (out_tuser == KIND_ECHO) && (out_tdata[OD_TASKS:OD_DONE] == 3'b000))
    else $error("unexpected multi-result sequence");

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);

// ===== bench/line_editor_checker.sv =====
// ----------------------------------------------------------------------------
// line_editor_checker: result predictor and comparator for the line editor
// Watches both stream channels of console_line_editor. Every accepted
// request is run through a private copy of the editor state (line buffer,
// fill count, ctrl-Y flag), and the results it should cause are queued.
// Every accepted result is compared field by field with the oldest queued
// one. Mismatch and pending counts are handed to the testbench top.
// ----------------------------------------------------------------------------
module line_editor_checker
  import cle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [15:0]           in_tdata,  // [7:0] rx_byte, [15:8] read_index
  input  logic [1:0]            in_tuser,  // [1:0] command
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata, // [7:0] data_byte, [8] line_done,
                                           // [9] magic_stats, [10] magic_tasks,
                                           // [18:11] line_length, [23:19] zero
  input  logic [1:0]            out_tuser, // [1:0] kind
  input  logic                  out_tlast, // last
  output int                    fail_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Rubout echo, first byte in the top bits.
  localparam logic [8*RUB_LEN-1:0] RUBOUT_ECHO = {
    CH_ESC, CH_BRACKET, CH_ONE, CH_D, CH_SPACE, CH_ESC, CH_BRACKET, CH_ONE, CH_D
  };

  // Private copy of the editor state.
  logic [7:0]        line_copy [LINE_DEPTH];
  logic [WIDE_W-1:0] copy_fill = '0;
  logic              ctrl_y_armed = 1'b0;

  // Results owed by the block, oldest first.
  res_t due_results[$];
  res_t due;
  int   errors = 0;

  // Queue one owed result; line_length is the fill after the request.
  task automatic owe_result(input kind_t kind, input logic [7:0] data, input logic last,
                            input logic done, input logic stats, input logic tasks);
    res_t r;
    r.kind  = kind;
    r.data  = data;
    r.last  = last;
    r.done  = done;
    r.stats = stats;
    r.tasks = tasks;
    r.len   = copy_fill[7:0];
    due_results.push_back(r);
  endtask

  // Advance the state copy by one request and queue what it causes.
  task automatic edit_line(input logic [1:0] cmd, input logic [7:0] rxb,
                           input logic [7:0] ridx);
    logic       stats_hit;
    logic       tasks_hit;
    logic [7:0] ch;
    logic [7:0] rd;
    int         k;
    case (cmd)
      CMD_RX: begin
        // The magic-key check sees every received byte, edits included.
        stats_hit    = ctrl_y_armed && (rxb == CH_G);
        tasks_hit    = ctrl_y_armed && (rxb == CH_P);
        ctrl_y_armed = (rxb == CH_CTRLY);
        if (rxb == CH_BS || rxb == CH_DEL) begin
          // An empty line swallows the rubout silently.
          if (copy_fill != '0) begin
            copy_fill = copy_fill - 1'b1;
            for (k = 0; k < RUB_LEN; k++) begin
              owe_result(KIND_ECHO, RUBOUT_ECHO[8*(RUB_LEN-1-k) +: 8], k == RUB_LEN - 1,
                         1'b0, 1'b0, 1'b0);
            end
          end
        end else begin
          ch = (rxb == CH_CR) ? CH_LF : rxb;
          // A full line drops the byte but still echoes it.
          if (copy_fill < WIDE_W'(LINE_DEPTH - 1)) begin
            line_copy[copy_fill[IDX_W-1:0]] = ch;
            copy_fill = copy_fill + 1'b1;
          end
          owe_result(KIND_ECHO, ch, 1'b1, ch == CH_LF, stats_hit, tasks_hit);
        end
      end
      CMD_READ: begin
        rd = (WIDE_W'(ridx) < WIDE_W'(LINE_DEPTH)) ? line_copy[ridx] : 8'h00;
        owe_result(KIND_READ, rd, 1'b1, 1'b0, 1'b0, 1'b0);
      end
      CMD_CLEAR: begin
        copy_fill = '0;
        owe_result(KIND_CLEAR, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
      end
      default: begin
        // The unused command is ignored.
      end
    endcase
  endtask

  // Compare one field, four-state, so an X on the port counts as wrong.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Watch both channels at the sampling edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      copy_fill    = '0;
      ctrl_y_armed = 1'b0;
      due_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        edit_line(in_tuser, in_tdata[7:0], in_tdata[15:8]);
      end
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("result with nothing owed: kind %0h data %0h", out_tuser, out_tdata[7:0]);
          errors++;
        end else begin
          due = due_results.pop_front();
          check_field("kind", due.kind, out_tuser);
          check_field("data_byte", due.data, out_tdata[OD_DATA_LSB +: 8]);
          check_field("last", due.last, out_tlast);
          check_field("line_done", due.done, out_tdata[OD_DONE]);
          check_field("magic_stats", due.stats, out_tdata[OD_STATS]);
          check_field("magic_tasks", due.tasks, out_tdata[OD_TASKS]);
          check_field("line_length", due.len, out_tdata[OD_LEN_LSB +: 8]);
          check_field("tdata padding", 0, out_tdata[OUT_DATA_W-1:OD_LEN_LSB+8]);
        end
      end
    end
    fail_count    <= errors;
    pending_count <= due_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the console line editor
// Drives console_line_editor with a short directed run (empty and full
// line, rubouts, CR, magic keys, reads, clear, unused command), a long line
// that fills the buffer, then random typing sessions with noise. The sender
// works in bursts with gaps and the receiver stalls on patterns of its own;
// line_editor_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top
  import cle_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 170;
  localparam int         IDLE_LIMIT   = 400;
  localparam int         TAIL_CYCLES  = 12;

  // Receiver stall patterns.
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_CHOKE  = 3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  int                    fail_count;
  int                    pending_count;

  // Sender bookkeeping: the written buffer entries always form a prefix.
  int typed_fill = 0;
  int written_top = 0;
  int accepted_items = 0;
  int burst_left = 0;
  bit sender_steady = 1'b0;
  int random_start;
  int word_len;
  int idle_cycles = 0;

  // Receiver pattern state.
  int stall_mode = RX_OPEN;
  int mode_left = 0;
  int hold_left = 0;
  int tick = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  console_line_editor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  line_editor_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // Receiver: switch between stall patterns.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(RX_OPEN, RX_CHOKE);
      mode_left  = $urandom_range(20, 90);
    end else begin
      mode_left--;
    end
    tick++;
    case (stall_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= (tick % 3 == 0);
      default: begin
        // Long stalls broken by short ready windows.
        if (hold_left == 0) begin
          hold_left = out_tready ? $urandom_range(3, 12) : $urandom_range(1, 4);
          out_tready <= !out_tready;
        end else begin
          hold_left--;
        end
      end
    endcase
  end

  // Watchdog: too long without any accepted request or result.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one request, hold it until accepted, then maybe open a gap.
  task automatic issue_request(input logic [1:0] cmd, input logic [7:0] rxb,
                               input logic [7:0] ridx);
    int gap;
    @(negedge clk);
    in_tuser  <= cmd;
    in_tdata  <= {ridx, rxb};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    // Track the fill so that reads only touch entries already written.
    if (cmd == CMD_RX) begin
      if (rxb == CH_BS || rxb == CH_DEL) begin
        if (typed_fill > 0) typed_fill--;
      end else if (typed_fill < LINE_DEPTH - 1) begin
        typed_fill++;
        if (typed_fill > written_top) written_top = typed_fill;
      end
    end else if (cmd == CMD_CLEAR) begin
      typed_fill = 0;
    end
    if (cmd != CMD_UNUSED) accepted_items++;
    // Burst ends: pick the next burst and a gap before it.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] c);
    issue_request(CMD_RX, c, 8'($urandom_range(0, 255)));
  endtask

  task automatic read_entry(input logic [7:0] idx);
    issue_request(CMD_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic clear_line();
    issue_request(CMD_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // A written entry, often one of the edges of the written range.
  function automatic logic [7:0] pick_read_index();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'(written_top - 1);
      default: return 8'($urandom_range(0, written_top - 1));
    endcase
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-line rubouts, magic keys, CR, extreme bytes.
    send_byte(CH_BS);
    send_byte(CH_DEL);
    send_byte(CH_CTRLY);
    send_byte(CH_G);
    send_byte(CH_CTRLY);
    send_byte(CH_P);
    // A rubout right after ctrl-Y disarms the magic key.
    send_byte(CH_CTRLY);
    send_byte(CH_BS);
    send_byte(CH_G);
    send_byte(CH_CTRLY);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_DEL);
    read_entry(8'd0);
    read_entry(8'(written_top - 1));
    // Clear keeps the old contents readable.
    clear_line();
    read_entry(8'd1);
    issue_request(CMD_UNUSED, 8'hFF, 8'hFF);
    send_byte(8'h78);
    read_entry(8'd0);

    // Fill the line to the top without gaps, then work at a full line.
    sender_steady = 1'b1;
    clear_line();
    repeat (LINE_DEPTH + 1) send_byte(printable());
    sender_steady = 1'b0;
    send_byte(CH_BS);
    send_byte(printable());
    send_byte(printable());
    send_byte(CH_CR);
    send_byte(CH_CTRLY);
    send_byte(CH_P);
    read_entry(8'(LINE_DEPTH - 2));
    read_entry(8'd128);
    read_entry(8'($urandom_range(128, LINE_DEPTH - 2)));
    clear_line();

    // Random typing sessions with reads, clears and noise.
    random_start = accepted_items;
    while (accepted_items < random_start + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // A word, sometimes corrected, sometimes ended by a newline.
          word_len = $urandom_range(1, 10);
          repeat (word_len) begin
            if ($urandom_range(0, 5) == 0) begin
              send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
            end else begin
              send_byte(printable());
            end
          end
          case ($urandom_range(0, 3))
            0:       send_byte(CH_CR);
            1:       send_byte(CH_LF);
            default: ;
          endcase
        end
        4: begin
          send_byte(CH_CTRLY);
          case ($urandom_range(0, 3))
            0:       send_byte(CH_G);
            1:       send_byte(CH_P);
            2:       send_byte(CH_BS);
            default: send_byte(printable());
          endcase
        end
        5, 6: begin
          if (written_top > 0) begin
            repeat ($urandom_range(1, 4)) read_entry(pick_read_index());
          end
        end
        7: clear_line();
        8: begin
          if ($urandom_range(0, 4) == 0) begin
            issue_request(CMD_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          end else begin
            send_byte(8'($urandom_range(0, 255)));
          end
        end
        default: begin
          repeat ($urandom_range(1, 5)) send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
        end
      endcase
    end

    // Drain, then give the block time to show anything extra.
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cle_pkg.sv
sv/console_line_editor.sv
sv/cle_checker.sv
bench/line_editor_checker.sv
bench/tb_top.sv
